// ===== hdl/xsbc_pkg.sv =====
// ----------------------------------------------------------------------------
// xsbc_pkg
// shared types and constants for the xor subarray below-bound counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xsbc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = 11;
    localparam int unsigned TOT_W  = 20;
    localparam int unsigned PADDR_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    // register index, taken from paddr[2]
    localparam logic REG_XOR_BOUND = 1'b0;

    typedef struct packed {
        logic [DATA_W-1:0] element_value;
        logic              start_of_array;
    } t_in_beat;

    typedef struct packed {
        logic [CNT_W-1:0] count_ending_here;
        logic [TOT_W-1:0] running_total;
        logic             pool_full;
    } t_out_beat;

endpackage

`default_nettype wire

// ===== hdl/xsbc_ram.sv =====
// ----------------------------------------------------------------------------
// xsbc_ram
// generic memory, one write port and one read port with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xsbc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/xsbc_cfg.sv =====
// ----------------------------------------------------------------------------
// xsbc_cfg
// apb register file holding the xor bound
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xsbc_cfg import xsbc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,
    output logic      [DATA_W-1:0]  o_bound
);

    logic [DATA_W-1:0] r_bound;
    logic              w_sel_bound;

    assign w_sel_bound = (paddr[2] == REG_XOR_BOUND);
    assign pready      = 1'b1;
    assign prdata      = w_sel_bound ? r_bound : '0;
    assign o_bound     = r_bound;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound <= '0;
        end else if (psel && penable && pwrite && w_sel_bound) begin
            r_bound <= pwdata;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/xsbc_seq.sv =====
// ----------------------------------------------------------------------------
// xsbc_seq
// trie sequencer: query walk, optional room check walk, insert walk, all
// through one node memory and one shared node update unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xsbc_seq import xsbc_pkg::*; #(
    parameter int unsigned VALUE_BITS = 32,
    parameter int unsigned MAX_ITEMS  = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [DATA_W-1:0] i_bound,
    input  wire logic              i_start,
    input  wire t_in_beat          i_item,
    output logic                   o_idle,
    output logic                   o_res_valid,
    input  wire logic              i_res_take,
    output t_out_beat              o_res
);

    localparam int unsigned POOL_NODES = VALUE_BITS * MAX_ITEMS + 1;
    localparam int unsigned A_W   = $clog2(POOL_NODES);
    localparam int unsigned NF_W  = $clog2(POOL_NODES + 1);
    localparam int unsigned LVL_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int unsigned W_W   = 2 * A_W + 2 * CNT_W;
    localparam logic [LVL_W-1:0] LVL_TOP  = LVL_W'(VALUE_BITS - 1);
    localparam logic [NF_W:0]    POOL_EXT = (NF_W + 1)'(POOL_NODES);
    localparam logic [NF_W:0]    VB_EXT   = (NF_W + 1)'(VALUE_BITS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_QRY  = 6'b000010,
        S_CHK  = 6'b000100,
        S_INS  = 6'b001000,
        S_ALC  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic                r_out_wait, n_out_wait;
    logic [VALUE_BITS-1:0] r_prefix, n_prefix;
    logic [TOT_W-1:0]    r_total, n_total;
    logic [NF_W-1:0]     r_next_free, n_next_free;
    logic [W_W-1:0]      r_root_word, n_root_word;
    logic [CNT_W-1:0]    r_root_cnt, n_root_cnt;
    logic [LVL_W-1:0]    r_lvl, n_lvl;
    logic                r_at_root, n_at_root;
    logic [A_W-1:0]      r_cur, n_cur;
    logic [CNT_W-1:0]    r_sum, n_sum;
    logic                r_full, n_full;

    logic [W_W-1:0]  w_word, w_new_word, w_alc_word, ram_rdata, ram_wdata;
    logic [A_W-1:0]  ram_raddr, ram_waddr;
    logic            ram_we;
    logic [A_W-1:0]  w_c0, w_c1, w_ch_pb, w_ch_np, w_q_nxt, w_child_new, w_nf_idx;
    logic [CNT_W-1:0] w_n0, w_n1, w_n_pb, w_n_inc, w_add, w_qsat, w_base, w_fin;
    logic [CNT_W-1:0] w_root_inc;
    logic [CNT_W:0]  w_qsum, w_fsum;
    logic [VALUE_BITS-1:0] w_bound_v;
    logic            w_pb, w_kb, w_bound_hi, w_lt, w_q_last, w_alloc;
    logic            w_skip_chk, w_chk_full;
    logic [TOT_W:0]  w_tsum;

    xsbc_ram #(
        .WIDTH (W_W),
        .DEPTH (POOL_NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // node word: child0, child1, pass count of child0, pass count of child1
    assign w_word = r_at_root ? r_root_word : ram_rdata;
    assign w_c0   = w_word[A_W-1:0];
    assign w_c1   = w_word[2*A_W-1:A_W];
    assign w_n0   = w_word[2*A_W+CNT_W-1:2*A_W];
    assign w_n1   = w_word[W_W-1:2*A_W+CNT_W];

    assign w_bound_v  = i_bound[VALUE_BITS-1:0];
    assign w_bound_hi = ((i_bound >> VALUE_BITS) != '0);
    assign w_pb       = r_prefix[r_lvl];
    assign w_kb       = w_bound_v[r_lvl];
    assign w_ch_pb    = w_pb ? w_c1 : w_c0;
    assign w_ch_np    = w_pb ? w_c0 : w_c1;
    assign w_n_pb     = w_pb ? w_n1 : w_n0;
    assign w_nf_idx   = r_next_free[A_W-1:0];

    // query step
    assign w_add    = (w_kb && (w_ch_pb != '0)) ? w_n_pb : '0;
    assign w_qsum   = {1'b0, r_sum} + {1'b0, w_add};
    assign w_qsat   = w_qsum[CNT_W] ? CNT_MAX : w_qsum[CNT_W-1:0];
    assign w_q_nxt  = w_kb ? w_ch_np : w_ch_pb;
    assign w_q_last = w_bound_hi || (w_q_nxt == '0) || (r_lvl == '0);
    assign w_lt     = ({{(DATA_W-VALUE_BITS){1'b0}}, r_prefix} < i_bound);
    assign w_base   = w_bound_hi ? r_root_cnt : w_qsat;
    assign w_fsum   = {1'b0, w_base} + (CNT_W + 1)'(w_lt);
    assign w_fin    = w_fsum[CNT_W] ? CNT_MAX : w_fsum[CNT_W-1:0];

    // room check
    assign w_skip_chk = ({1'b0, r_next_free} + VB_EXT) <= POOL_EXT;
    assign w_chk_full = ({1'b0, r_next_free} + (NF_W + 1)'(r_lvl) + (NF_W + 1)'(1)) > POOL_EXT;

    // insert step
    assign w_n_inc     = (w_n_pb == CNT_MAX) ? w_n_pb : w_n_pb + CNT_W'(1);
    assign w_root_inc  = (r_root_cnt == CNT_MAX) ? r_root_cnt : r_root_cnt + CNT_W'(1);
    assign w_alloc     = (w_ch_pb == '0);
    assign w_child_new = w_alloc ? w_nf_idx : w_ch_pb;
    assign w_new_word  = {w_pb ? w_n_inc : w_n1,
                          w_pb ? w_n0 : w_n_inc,
                          w_pb ? w_child_new : w_c1,
                          w_pb ? w_c0 : w_child_new};
    assign w_alc_word  = {w_pb ? CNT_W'(1) : CNT_W'(0),
                          w_pb ? CNT_W'(0) : CNT_W'(1),
                          w_pb ? w_nf_idx : A_W'(0),
                          w_pb ? A_W'(0) : w_nf_idx};

    assign w_tsum = {1'b0, r_total} + (TOT_W + 1)'(r_sum);

    always_comb begin
        ram_raddr = w_ch_pb;
        ram_waddr = r_cur;
        ram_wdata = w_new_word;
        ram_we    = 1'b0;
        unique case (r_state)
            S_QRY: begin
                ram_raddr = w_q_nxt;
            end
            S_INS: begin
                ram_we = !r_at_root;
            end
            S_ALC: begin
                ram_we    = 1'b1;
                ram_wdata = w_alc_word;
            end
            default: begin
                ram_raddr = w_ch_pb;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_out_wait  = r_out_wait;
        n_prefix    = r_prefix;
        n_total     = r_total;
        n_next_free = r_next_free;
        n_root_word = r_root_word;
        n_root_cnt  = r_root_cnt;
        n_lvl       = r_lvl;
        n_at_root   = r_at_root;
        n_cur       = r_cur;
        n_sum       = r_sum;
        n_full      = r_full;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_item.start_of_array) begin
                        n_prefix    = i_item.element_value[VALUE_BITS-1:0];
                        n_total     = '0;
                        n_next_free = NF_W'(1);
                        n_root_word = '0;
                        n_root_cnt  = '0;
                    end else begin
                        n_prefix = r_prefix ^ i_item.element_value[VALUE_BITS-1:0];
                    end
                    n_state   = S_QRY;
                    n_lvl     = LVL_TOP;
                    n_at_root = 1'b1;
                    n_sum     = '0;
                end
            end
            S_QRY: begin
                if (w_q_last) begin
                    n_sum     = w_fin;
                    n_lvl     = LVL_TOP;
                    n_at_root = 1'b1;
                    n_full    = 1'b0;
                    n_state   = w_skip_chk ? S_INS : S_CHK;
                end else begin
                    n_sum     = w_qsat;
                    n_lvl     = r_lvl - LVL_W'(1);
                    n_at_root = 1'b0;
                end
            end
            S_CHK: begin
                if (w_ch_pb == '0 || r_lvl == '0) begin
                    n_full    = (w_ch_pb == '0) && w_chk_full;
                    n_state   = n_full ? S_DONE : S_INS;
                    n_lvl     = LVL_TOP;
                    n_at_root = 1'b1;
                end else begin
                    n_lvl     = r_lvl - LVL_W'(1);
                    n_at_root = 1'b0;
                end
            end
            S_INS: begin
                if (r_at_root) begin
                    n_root_word = w_new_word;
                    n_root_cnt  = w_root_inc;
                end
                if (w_alloc) begin
                    n_next_free = r_next_free + NF_W'(1);
                end
                n_cur     = w_child_new;
                n_at_root = 1'b0;
                if (r_lvl == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_lvl   = r_lvl - LVL_W'(1);
                    n_state = w_alloc ? S_ALC : S_INS;
                end
            end
            S_ALC: begin
                n_next_free = r_next_free + NF_W'(1);
                n_cur       = w_nf_idx;
                if (r_lvl == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_lvl = r_lvl - LVL_W'(1);
                end
            end
            S_DONE: begin
                if (!r_out_wait) begin
                    n_total    = w_tsum[TOT_W] ? TOT_MAX : w_tsum[TOT_W-1:0];
                    n_out_wait = 1'b1;
                end else if (i_res_take) begin
                    n_out_wait = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_wait  <= 1'b0;
            r_prefix    <= '0;
            r_total     <= '0;
            r_next_free <= NF_W'(1);
            r_root_word <= '0;
            r_root_cnt  <= '0;
            r_lvl       <= LVL_TOP;
            r_at_root   <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_out_wait  <= n_out_wait;
            r_prefix    <= n_prefix;
            r_total     <= n_total;
            r_next_free <= n_next_free;
            r_root_word <= n_root_word;
            r_root_cnt  <= n_root_cnt;
            r_lvl       <= n_lvl;
            r_at_root   <= n_at_root;
        end
        r_cur  <= n_cur;
        r_sum  <= n_sum;
        r_full <= n_full;
    end

    assign o_idle                  = (r_state == S_IDLE);
    assign o_res_valid             = (r_state == S_DONE) && r_out_wait;
    assign o_res.count_ending_here = r_sum;
    assign o_res.running_total     = r_total;
    assign o_res.pool_full         = r_full;

endmodule

`default_nettype wire

// ===== hdl/xor_subarray_below_bound_counter_unit.sv =====
// ----------------------------------------------------------------------------
// xor_subarray_below_bound_counter_unit
// counts subarrays ending at each element whose xor is below a bound
// ----------------------------------------------------------------------------
// order: query walk, then a room check walk when the pool is within
// VALUE_BITS nodes of full, then insert walk, then the result is registered
// throughput: one beat in flight; next beat taken at the edge after the
// result leaves the sequencer; each walk visits one trie node per cycle
// reset: clears bound, prefix, total, root node and allocator; no memory sweep
`timescale 1ns / 1ps
`default_nettype none

module xor_subarray_below_bound_counter_unit import xsbc_pkg::*; #(
    parameter int unsigned VALUE_BITS = 32,
    parameter int unsigned MAX_ITEMS  = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_beat           i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_beat               o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready
);

    logic [DATA_W-1:0] w_bound;
    logic              w_idle, w_res_valid, w_take;
    t_out_beat         w_res;
    logic              r_out_valid;
    t_out_beat         r_out;

    xsbc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_bound (w_bound)
    );

    xsbc_seq #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_ITEMS  (MAX_ITEMS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bound     (w_bound),
        .i_start     (i_in_valid && w_idle),
        .i_item      (i_in),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_take),
        .o_res       (w_res)
    );

    assign w_take = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_valid && w_take) begin
            r_out <= w_res;
        end
    end

    assign o_in_ready  = w_idle;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== hdl/xsbc_checker.sv =====
// ----------------------------------------------------------------------------
// xsbc_checker
// port level checks for the xor subarray below-bound counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xsbc_checker import xsbc_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_beat o_out
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result beat dropped or changed under stall");

    // an accepted beat keeps the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again right after accept");

    // total includes this beat's count
    a_total_covers_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.running_total >= TOT_W'(o_out.count_ending_here)))
        else $error("running total below count");

    // reset empties the output stage
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid after reset");

endmodule

bind xor_subarray_below_bound_counter_unit xsbc_checker u_xsbc_checker (.*);

`default_nettype wire
